>>> rtl/tqr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqr_pkg
// Shared types and defaults for the thread queue with removal by id.
// ----------------------------------------------------------------------------
package tqr_pkg;

  localparam int unsigned DEPTH_DEF   = 16;
  localparam int unsigned ID_BITS_DEF = 16;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_TAKE   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_LOOKUP = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAKE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_e;

endpackage

>>> rtl/thread_queue_remove_by_id.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thread_queue_remove_by_id
// Ordered thread-id queue: append, take head, remove by id, look up by id.
// ----------------------------------------------------------------------------
// usage
//   input channel: op_i and thread_id_i with in_valid_i; a transfer happens
//   when in_valid_i is high and in_stall_o is low. in_stall_o is high while
//   an operation is in flight, so one operation is worked on at a time.
//   output channel: status_o, result_id_o, occupancy_o with out_valid_o; a
//   transfer happens when out_valid_o is high and out_stall_i is low.
//   every operation gives exactly one result.
// sequence (input transfer to result on the output register)
//   append goes straight to the done step; take head reads the head in a
//   take step; remove and look up scan from the head, and removing any
//   entry but the last also moves each later entry forward one slot. the
//   ids live in a circular buffer in a one-port-read, one-port-write memory
//   with a registered read; the scan and the gap closing walk it one entry
//   a cycle; the next input can be taken in the cycle after the result loads.
// reset: queue empty, output register empty. memory contents are not
//   cleared; only entries below the count are ever used.
// stall: a finished result waits in the pending stage until the output
//   register is free; meanwhile no new input transfer is taken.
// ----------------------------------------------------------------------------
module thread_queue_remove_by_id
  import tqr_pkg::*;
#(
  parameter int unsigned DEPTH   = DEPTH_DEF,
  parameter int unsigned ID_BITS = ID_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] thread_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [15:0] result_id_o,
  output logic [4:0]  occupancy_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  // id storage
  logic [ID_BITS-1:0] mem_q [DEPTH];
  logic [ID_BITS-1:0] rdata_q;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               we;
  logic [AW-1:0]      wa;
  logic [ID_BITS-1:0] wd;

  // control
  state_e             state_q, state_d;
  op_e                op_q, op_d;
  logic [ID_BITS-1:0] key_q, key_d;
  logic [AW-1:0]      head_q, head_d;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      off_q, off_d;

  // pending result
  status_e            res_status_q, res_status_d;
  logic [15:0]        res_id_q, res_id_d;

  // output register
  logic               out_valid_q, out_valid_d;
  status_e            out_status_q, out_status_d;
  logic [15:0]        out_id_q, out_id_d;
  logic [4:0]         out_occ_q, out_occ_d;

  logic               accept;
  logic               empty;
  logic               full;
  logic               match;
  logic               last;
  logic               out_free;
  logic [ID_BITS-1:0] key_in;
  op_e                op_in;

  // logical offset from head to physical slot
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [CW-1:0] off);
    logic [CW-1:0] sum;
    sum = CW'(head) + off;
    if (sum >= DepthC) begin
      sum = sum - DepthC;
    end
    return sum[AW-1:0];
  endfunction

  assign accept   = (state_q == S_IDLE) && in_valid_i;
  assign empty    = (count_q == '0);
  assign full     = (count_q == DepthC);
  assign match    = (rdata_q == key_q);
  assign last     = (off_q == count_q - CW'(1));
  assign out_free = !out_valid_q || !out_stall_i;
  assign key_in   = ID_BITS'(thread_id_i);
  assign op_in    = op_e'(op_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (op_in)
            OP_APPEND: state_d = S_DONE;
            OP_TAKE:   state_d = empty ? S_DONE : S_TAKE;
            OP_REMOVE,
            OP_LOOKUP: state_d = empty ? S_DONE : S_SCAN;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_TAKE: state_d = S_DONE;
      S_SCAN: begin
        if (match) begin
          state_d = (op_q == OP_REMOVE && !last) ? S_SHIFT : S_DONE;
        end else if (last) begin
          state_d = S_DONE;
        end
      end
      S_SHIFT: begin
        if (last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    op_d         = op_q;
    key_d        = key_q;
    head_d       = head_q;
    count_d      = count_q;
    off_d        = off_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    rd_en        = 1'b0;
    rd_addr      = phys(head_q, off_q + CW'(1));
    we           = 1'b0;
    wa           = phys(head_q, count_q);
    wd           = key_in;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_id_d     = out_id_q;
    out_occ_d    = out_occ_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d         = op_in;
          key_d        = key_in;
          off_d        = '0;
          rd_en        = 1'b1;
          rd_addr      = head_q;
          res_id_d     = '0;
          res_status_d = ST_OK;
          unique case (op_in)
            OP_APPEND: begin
              if (full) begin
                res_status_d = ST_FULL;
              end else begin
                we      = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            OP_TAKE: begin
              if (empty) begin
                res_status_d = ST_EMPTY;
              end
            end
            OP_REMOVE,
            OP_LOOKUP: begin
              if (empty) begin
                res_status_d = ST_MISSING;
              end
            end
            default: res_status_d = ST_OK;
          endcase
        end
      end
      S_TAKE: begin
        res_id_d = 16'(rdata_q);
        head_d   = phys(head_q, CW'(1));
        count_d  = count_q - CW'(1);
      end
      S_SCAN: begin
        if (match) begin
          res_id_d = 16'(rdata_q);
          if (op_q == OP_REMOVE) begin
            if (last) begin
              count_d = count_q - CW'(1);
            end else begin
              rd_en = 1'b1;
              off_d = off_q + CW'(1);
            end
          end
        end else if (last) begin
          res_status_d = ST_MISSING;
        end else begin
          rd_en = 1'b1;
          off_d = off_q + CW'(1);
        end
      end
      S_SHIFT: begin
        // move the entry just read one slot toward the head
        we = 1'b1;
        wa = phys(head_q, off_q - CW'(1));
        wd = rdata_q;
        if (last) begin
          count_d = count_q - CW'(1);
        end else begin
          rd_en = 1'b1;
          off_d = off_q + CW'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_id_d     = res_id_q;
          out_occ_d    = 5'(count_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    off_q        <= off_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    out_status_q <= out_status_d;
    out_id_q     <= out_id_d;
    out_occ_q    <= out_occ_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign result_id_o = out_id_q;
  assign occupancy_o = out_occ_q;

endmodule
